[design/xo_pkg.sv]
`default_nettype none

package xo_pkg;

   localparam int WordBits = 64;
   localparam int ValueBits = WordBits - 1;
   localparam int RotOut = 23;
   localparam int ShiftT = 17;
   localparam int RotS3 = 45;
   localparam int StateWords = 4;
   localparam int SlotBits = $clog2(StateWords);

   typedef logic [WordBits-1:0] word_type;
   typedef logic [ValueBits-1:0] value_type;
   typedef logic [SlotBits-1:0] slot_type;

   typedef enum logic [0:0] {
      CMD_GENERATE = 1'b0,
      CMD_SEED     = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_GENERATED = 2'd0,
      STATUS_UNSEEDED  = 2'd1,
      STATUS_SEEDED    = 2'd2
   } status_type;

   // request handed to the state unit when it leaves the input register
   typedef struct packed {
      logic        step;
      command_type command;
      slot_type    seed_slot;
      word_type    seed_word;
   } state_req_type;

   // what the state unit shows for the request at its input
   typedef struct packed {
      status_type status;
      word_type   sum;
      word_type   s0;
   } state_rsp_type;

   function automatic word_type rotl(word_type x, int unsigned k);
      return (x << k) | (x >> (WordBits - k));
   endfunction

endpackage

`default_nettype wire

[design/xoshiro256pp_generator.sv]
// xoshiro256++ generator. Each request either loads one of the four 64-bit
// state words (tuser = 1, slot and word in tdata) or asks for one number
// (tuser = 0). Every request returns exactly one response: tdata carries the
// absolute value of the signed 64-bit output (most negative saturates to the
// largest positive), tuser the status: 0 number generated, 1 state all zero
// so nothing generated, 2 seed word stored. State resets to all zero. A new
// request is taken every cycle while rsp_tready back-pressure does not stall the
// pipeline; each request passes through the input register, the state/sum
// stage, the output add stage and the absolute-value stage of the pipeline.
`default_nettype none

module xoshiro256pp_generator
   import xo_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,  // seed_slot[1:0], seed_word[65:2], zero pad
   input  wire logic        req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // random_value[62:0], zero pad
   output logic [1:0]       rsp_tuser   // status
);

   logic          v1_ff;
   command_type   cmd1_ff;
   slot_type      slot1_ff;
   word_type      word1_ff;

   logic          v2_ff;
   status_type    status2_ff;
   word_type      sum2_ff;
   word_type      s02_ff;

   logic          v3_ff;
   status_type    status3_ff;
   word_type      raw3_ff;

   logic          v4_ff;
   status_type    status4_ff;
   value_type     value4_ff;

   logic          move12;
   logic          move23;
   logic          move34;
   logic          accept;
   state_req_type state_req;
   state_rsp_type state_rsp;
   word_type      raw_in;
   value_type     value_in;

   assign move34     = v3_ff && (!v4_ff || rsp_tready);
   assign move23     = v2_ff && (!v3_ff || move34);
   assign move12     = v1_ff && (!v2_ff || move23);
   assign req_tready = !v1_ff || move12;
   assign accept     = req_tvalid && req_tready;

   assign state_req.step      = move12;
   assign state_req.command   = cmd1_ff;
   assign state_req.seed_slot = slot1_ff;
   assign state_req.seed_word = word1_ff;

   xo_state u_state (
      .clock   (clock),
      .reset   (reset),
      .request (state_req),
      .result  (state_rsp)
   );

   always_comb begin
      if (status2_ff == STATUS_GENERATED) begin
         raw_in = rotl(sum2_ff, RotOut) + s02_ff;
      end else begin
         raw_in = '0;
      end
   end

   always_comb begin
      word_type neg;
      neg = -raw3_ff;
      if (!raw3_ff[WordBits-1]) begin
         value_in = raw3_ff[ValueBits-1:0];
      end else if (raw3_ff[ValueBits-1:0] == '0) begin
         value_in = '1;
      end else begin
         value_in = neg[ValueBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            v1_ff <= req_tvalid;
         end
         if (!v2_ff || move23) begin
            v2_ff <= move12;
         end
         if (!v3_ff || move34) begin
            v3_ff <= move23;
         end
         if (!v4_ff || rsp_tready) begin
            v4_ff <= move34;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd1_ff  <= command_type'(req_tuser);
         slot1_ff <= req_tdata[SlotBits-1:0];
         word1_ff <= req_tdata[SlotBits +: WordBits];
      end
      if (move12) begin
         status2_ff <= state_rsp.status;
         sum2_ff    <= state_rsp.sum;
         s02_ff     <= state_rsp.s0;
      end
      if (move23) begin
         status3_ff <= status2_ff;
         raw3_ff    <= raw_in;
      end
      if (move34) begin
         status4_ff <= status3_ff;
         value4_ff  <= value_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {1'b0, value4_ff};
   assign rsp_tuser  = status4_ff;

endmodule

`default_nettype wire

[design/xo_state.sv]
`default_nettype none

module xo_state
   import xo_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire state_req_type request,
   output state_rsp_type      result
);

   word_type state_ff [StateWords];
   word_type state_in [StateWords];
   logic     seeded;

   assign seeded = |{state_ff[0], state_ff[1], state_ff[2], state_ff[3]};

   always_comb begin
      word_type t;
      word_type s0;
      word_type s1;
      word_type s2;
      word_type s3;

      t  = state_ff[1] << ShiftT;
      s2 = state_ff[2] ^ state_ff[0];
      s3 = state_ff[3] ^ state_ff[1];
      s1 = state_ff[1] ^ s2;
      s0 = state_ff[0] ^ s3;
      s2 = s2 ^ t;
      s3 = rotl(s3, RotS3);

      for (int i = 0; i < StateWords; i++) begin
         state_in[i] = state_ff[i];
      end

      result.s0  = state_ff[0];
      result.sum = state_ff[0] + state_ff[3];
      if (request.command == CMD_SEED) begin
         result.status = STATUS_SEEDED;
      end else if (!seeded) begin
         result.status = STATUS_UNSEEDED;
      end else begin
         result.status = STATUS_GENERATED;
      end

      if (request.step) begin
         if (request.command == CMD_SEED) begin
            state_in[request.seed_slot] = request.seed_word;
         end else if (seeded) begin
            state_in[0] = s0;
            state_in[1] = s1;
            state_in[2] = s2;
            state_in[3] = s3;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < StateWords; i++) begin
         if (reset) begin
            state_ff[i] <= '0;
         end else begin
            state_ff[i] <= state_in[i];
         end
      end
   end

endmodule

`default_nettype wire

[design/xo_checker.sv]
`default_nettype none

module xo_checker
   import xo_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [71:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_GENERATED || rsp_tuser == STATUS_UNSEEDED ||
                     rsp_tuser == STATUS_SEEDED)
      else $error("bad status");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_GENERATED |-> rsp_tdata == '0)
      else $error("nonzero value without a generated number");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

endmodule

bind xoshiro256pp_generator xo_checker u_xo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
